>>> rtl/arc_pkg.sv
// arc_pkg: shared widths, codes and result structs for the range coalescer.
// No dependencies; used by every file under rtl/.
package arc_pkg;

  localparam int POS_WIDTH      = 48;   // start / extent width
  localparam int TOTAL_WIDTH    = 31;   // run lengths, totals, tallies
  localparam int LEN_WIDTH      = 32;   // signed count on the input
  localparam int OUT_WIDTH      = 31;   // width of the total ports
  localparam int CODE_WIDTH     = 3;
  localparam int CFG_IDX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH = POS_WIDTH;
  // range ends never wrap: wide enough for start + count
  localparam int END_WIDTH      = ((POS_WIDTH > LEN_WIDTH - 1) ? POS_WIDTH : LEN_WIDTH - 1) + 1;
  localparam int SUM_WIDTH      = LEN_WIDTH + 1;

  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_IDX_WIDTH = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = '1;

  typedef enum logic [CODE_WIDTH-1:0] {
    ERR_OK            = 3'd0,
    ERR_NEG_COUNT     = 3'd1,
    ERR_START_LOW     = 3'd2,
    ERR_NOT_ASCENDING = 3'd3,
    ERR_BEYOND_EXTENT = 3'd4,
    ERR_TOO_LARGE     = 3'd5
  } err_code_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_EXTENT    = 1'b0,
    CFG_UNBOUNDED = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0]   run_start;
    logic [TOTAL_WIDTH-1:0] run_length;
    err_code_t              error_code;
    logic [TOTAL_WIDTH-1:0] selected_total;
    logic [TOTAL_WIDTH-1:0] runs_total;
    logic [TOTAL_WIDTH-1:0] items_seen;
    logic                   final_res;
  } result_t;

  // up to two results per request; res0 is always filled first
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

>>> rtl/arc_core.sv
// arc_core: input register, list state and the per-request checks and merge.
// Depends on arc_pkg.
module arc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [arc_pkg::POS_WIDTH-1:0]  in_range_start,
  input  logic signed [arc_pkg::LEN_WIDTH-1:0] in_range_length,
  input  logic                           in_list_end,
  input  logic [arc_pkg::POS_WIDTH-1:0]  extent,
  input  logic                           extent_unbounded,
  input  logic                           room,
  output arc_pkg::push_t                 push
);

  logic                               in_valid_r;
  logic [arc_pkg::POS_WIDTH-1:0]      start_r;
  logic [arc_pkg::LEN_WIDTH-1:0]      len_r;
  logic                               last_r;

  logic [arc_pkg::END_WIDTH-1:0]      nexp_r, nexp_nxt;
  logic [arc_pkg::POS_WIDTH-1:0]      ors_r, ors_nxt;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    orl_r, orl_nxt;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    sum_r, sum_nxt;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    runs_r, runs_nxt;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    items_r, items_nxt;
  logic                               err_lat_r, err_lat_nxt;

  logic                               fire;
  logic                               neg;
  logic [arc_pkg::LEN_WIDTH-2:0]      len_mag;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    len_t;
  logic [arc_pkg::END_WIDTH-1:0]      start_ext, len_ext, end_v, nexp_v;
  logic [arc_pkg::SUM_WIDTH-1:0]      sum_ext;
  logic [arc_pkg::TOTAL_WIDTH-1:0]    items_inc;
  arc_pkg::err_code_t                 code;

  assign fire     = in_valid_r && room;
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_r <= in_range_start;
      len_r   <= in_range_length;
      last_r  <= in_list_end;
    end
  end

  // range checks
  always_comb begin
    neg       = len_r[arc_pkg::LEN_WIDTH-1];
    len_mag   = len_r[arc_pkg::LEN_WIDTH-2:0];
    len_t     = arc_pkg::TOTAL_WIDTH'(len_mag);
    start_ext = arc_pkg::END_WIDTH'(start_r);
    len_ext   = arc_pkg::END_WIDTH'(len_mag);
    nexp_v    = start_ext + len_ext;
    end_v     = nexp_v - arc_pkg::END_WIDTH'(1);
    sum_ext   = arc_pkg::SUM_WIDTH'(sum_r) + arc_pkg::SUM_WIDTH'(len_mag);
    items_inc = (items_r != arc_pkg::TOT_MAX) ? items_r + arc_pkg::TOTAL_WIDTH'(1) : items_r;

    code = arc_pkg::ERR_OK;
    if (neg) begin
      code = arc_pkg::ERR_NEG_COUNT;
    end else if (len_mag != '0) begin
      if (start_r == '0) begin
        code = arc_pkg::ERR_START_LOW;
      end else if (start_ext < nexp_r) begin
        code = arc_pkg::ERR_NOT_ASCENDING;
      end else if (!extent_unbounded && end_v > arc_pkg::END_WIDTH'(extent)) begin
        code = arc_pkg::ERR_BEYOND_EXTENT;
      end else if (sum_ext > arc_pkg::SUM_WIDTH'(arc_pkg::TOT_MAX)) begin
        code = arc_pkg::ERR_TOO_LARGE;
      end
    end
  end

  // merge, results and next list state
  always_comb begin
    nexp_nxt    = nexp_r;
    ors_nxt     = ors_r;
    orl_nxt     = orl_r;
    sum_nxt     = sum_r;
    runs_nxt    = runs_r;
    items_nxt   = items_r;
    err_lat_nxt = err_lat_r;
    push        = '0;

    if (fire) begin
      if (err_lat_r) begin
        // draining the rest of a failed list
        if (last_r) begin
          err_lat_nxt = 1'b0;
          nexp_nxt = '0; ors_nxt = '0; orl_nxt = '0;
          sum_nxt = '0; runs_nxt = '0; items_nxt = '0;
        end
      end else if (code != arc_pkg::ERR_OK) begin
        push.push0               = 1'b1;
        push.res0.error_code     = code;
        push.res0.selected_total = sum_r;
        push.res0.runs_total     = runs_r;
        push.res0.items_seen     = items_inc;
        push.res0.final_res      = 1'b1;
        if (last_r) begin
          nexp_nxt = '0; ors_nxt = '0; orl_nxt = '0;
          sum_nxt = '0; runs_nxt = '0; items_nxt = '0;
        end else begin
          items_nxt   = items_inc;
          err_lat_nxt = 1'b1;
        end
      end else begin
        items_nxt = items_inc;
        if (len_mag != '0) begin
          if (runs_r != '0 && start_ext == nexp_r) begin
            orl_nxt = orl_r + len_t;
          end else begin
            if (runs_r != '0) begin
              // previous run is closed
              push.push0           = 1'b1;
              push.res0.run_start  = ors_r;
              push.res0.run_length = orl_r;
              push.res0.error_code = arc_pkg::ERR_OK;
            end
            ors_nxt  = start_r;
            orl_nxt  = len_t;
            runs_nxt = runs_r + arc_pkg::TOTAL_WIDTH'(1);
          end
          nexp_nxt = nexp_v;
          sum_nxt  = sum_r + len_t;
        end
        if (last_r) begin
          if (push.push0) begin
            push.push1               = 1'b1;
            push.res1.run_start      = ors_nxt;
            push.res1.run_length     = orl_nxt;
            push.res1.error_code     = arc_pkg::ERR_OK;
            push.res1.selected_total = sum_nxt;
            push.res1.runs_total     = runs_nxt;
            push.res1.items_seen     = items_nxt;
            push.res1.final_res      = 1'b1;
          end else begin
            push.push0               = 1'b1;
            push.res0.run_start      = ors_nxt;
            push.res0.run_length     = orl_nxt;
            push.res0.error_code     = arc_pkg::ERR_OK;
            push.res0.selected_total = sum_nxt;
            push.res0.runs_total     = runs_nxt;
            push.res0.items_seen     = items_nxt;
            push.res0.final_res      = 1'b1;
          end
          nexp_nxt = '0; ors_nxt = '0; orl_nxt = '0;
          sum_nxt = '0; runs_nxt = '0; items_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nexp_r    <= '0;
      ors_r     <= '0;
      orl_r     <= '0;
      sum_r     <= '0;
      runs_r    <= '0;
      items_r   <= '0;
      err_lat_r <= 1'b0;
    end else begin
      nexp_r    <= nexp_nxt;
      ors_r     <= ors_nxt;
      orl_r     <= orl_nxt;
      sum_r     <= sum_nxt;
      runs_r    <= runs_nxt;
      items_r   <= items_nxt;
      err_lat_r <= err_lat_nxt;
    end
  end

endmodule

>>> rtl/arc_fifo.sv
// arc_fifo: small result queue, takes up to two results a cycle, gives one.
// Depends on arc_pkg.
module arc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  arc_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output arc_pkg::result_t head
);

  arc_pkg::result_t                     mem_r [arc_pkg::FIFO_DEPTH];
  logic [arc_pkg::FIFO_IDX_WIDTH-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [arc_pkg::FIFO_CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [arc_pkg::FIFO_IDX_WIDTH-1:0]   wr_p1;
  logic                                 pop;

  assign out_valid = cnt_r != '0;
  assign head      = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  // two free slots needed before the core may fire
  assign room      = cnt_r <= arc_pkg::FIFO_CNT_WIDTH'(arc_pkg::FIFO_DEPTH - 2);
  assign wr_p1     = wr_r + arc_pkg::FIFO_IDX_WIDTH'(1);

  always_comb begin
    wr_nxt  = wr_r + arc_pkg::FIFO_IDX_WIDTH'(push.push0) + arc_pkg::FIFO_IDX_WIDTH'(push.push1);
    rd_nxt  = rd_r + arc_pkg::FIFO_IDX_WIDTH'(pop);
    cnt_nxt = cnt_r + arc_pkg::FIFO_CNT_WIDTH'(push.push0)
                    + arc_pkg::FIFO_CNT_WIDTH'(push.push1)
                    - arc_pkg::FIFO_CNT_WIDTH'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wr_r]  <= push.res0;
    if (push.push1) mem_r[wr_p1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/ascending_range_coalescer.sv
// ascending_range_coalescer: top level; config registers, core and result queue.
// Depends on arc_pkg, arc_core, arc_fifo.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   in_      | in_valid / in_ready   | range_start, range_length, list_end
//   out_     | out_valid / out_ready | run, error_code, totals, final_res
//   cfg_     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One request per cycle sustained while the result queue has room; a result passes
// the input register, then the result queue, before out_valid.
// A request can yield two results (closed run plus list total); the queue
// holds four results, and the core fires only with two slots free.
// out_ready low fills the queue and then holds in_ready low.
// Reset is synchronous: list state, queue pointers and config clear at once;
// no clearing pass.
module ascending_range_coalescer (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [arc_pkg::POS_WIDTH-1:0]       in_range_start,
  input  logic signed [arc_pkg::LEN_WIDTH-1:0] in_range_length,
  input  logic                                in_list_end,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [arc_pkg::POS_WIDTH-1:0]       out_run_start,
  output logic [arc_pkg::OUT_WIDTH-1:0]       out_run_length,
  output logic [arc_pkg::CODE_WIDTH-1:0]      out_error_code,
  output logic [arc_pkg::OUT_WIDTH-1:0]       out_selected_total,
  output logic [arc_pkg::OUT_WIDTH-1:0]       out_runs_total,
  output logic [arc_pkg::OUT_WIDTH-1:0]       out_items_seen,
  output logic                                out_final_res,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [arc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [arc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  logic [arc_pkg::POS_WIDTH-1:0] extent_r;
  logic                          unbounded_r;
  logic                          fifo_room;
  arc_pkg::push_t                push;
  arc_pkg::result_t              head;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_r    <= '0;
      unbounded_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (arc_pkg::cfg_idx_t'(cfg_index))
        arc_pkg::CFG_EXTENT:    extent_r    <= cfg_wdata[arc_pkg::POS_WIDTH-1:0];
        arc_pkg::CFG_UNBOUNDED: unbounded_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // checks, merge and per-list tallies
  arc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_range_start  (in_range_start),
    .in_range_length (in_range_length),
    .in_list_end     (in_list_end),
    .extent          (extent_r),
    .extent_unbounded(unbounded_r),
    .room            (fifo_room),
    .push            (push)
  );

  // result queue decouples the two channels
  arc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (fifo_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_run_start      = head.run_start;
  assign out_run_length     = arc_pkg::OUT_WIDTH'(head.run_length);
  assign out_error_code     = head.error_code;
  assign out_selected_total = arc_pkg::OUT_WIDTH'(head.selected_total);
  assign out_runs_total     = arc_pkg::OUT_WIDTH'(head.runs_total);
  assign out_items_seen     = arc_pkg::OUT_WIDTH'(head.items_seen);
  assign out_final_res      = head.final_res;

  // second slot is only used behind the first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result pushed without first");

  // core never pushes into a queue without two free slots
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push0 || push.push1) |-> fifo_room)
    else $error("result pushed into full queue");

  // an error always closes the list
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != arc_pkg::ERR_OK) |-> out_final_res)
    else $error("error result without final flag");

  // a closed run carries no error, selected total or item count
  a_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_res) |->
      (out_error_code == arc_pkg::ERR_OK && out_selected_total == '0 &&
       out_items_seen == '0))
    else $error("intermediate run result carries totals");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for ascending_range_coalescer (range merge, errors, totals).
// Depends on rtl/arc_pkg.sv and rtl/ascending_range_coalescer.sv.
module tb_top;

  // one range request as the sender holds it
  typedef struct {
    logic [arc_pkg::POS_WIDTH-1:0]        start;
    logic signed [arc_pkg::LEN_WIDTH-1:0] count;
    logic                                 last;
  } range_req_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [arc_pkg::POS_WIDTH-1:0]        in_range_start = '0;
  logic signed [arc_pkg::LEN_WIDTH-1:0] in_range_length = '0;
  logic                                 in_list_end = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [arc_pkg::POS_WIDTH-1:0]        out_run_start;
  logic [arc_pkg::OUT_WIDTH-1:0]        out_run_length;
  logic [arc_pkg::CODE_WIDTH-1:0]       out_error_code;
  logic [arc_pkg::OUT_WIDTH-1:0]        out_selected_total;
  logic [arc_pkg::OUT_WIDTH-1:0]        out_runs_total;
  logic [arc_pkg::OUT_WIDTH-1:0]        out_items_seen;
  logic                                 out_final_res;
  logic                                 cfg_we = 1'b0;
  logic [arc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index = '0;
  logic [arc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata = '0;

  ascending_range_coalescer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_range_start     (in_range_start),
    .in_range_length    (in_range_length),
    .in_list_end        (in_list_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_run_start      (out_run_start),
    .out_run_length     (out_run_length),
    .out_error_code     (out_error_code),
    .out_selected_total (out_selected_total),
    .out_runs_total     (out_runs_total),
    .out_items_seen     (out_items_seen),
    .out_final_res      (out_final_res),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  range_req_t       pending_ranges[$];  // requests not yet offered to the block
  arc_pkg::result_t expected_runs[$];   // predicted results, oldest first
  int               send_idle = 30;     // percent of cycles the sender holds off
  int               recv_idle = 60;     // percent of cycles out_ready stays low
  int               n_bad = 0;

  // ---------------------------------------------------------------------------
  // Shadow of the coalescer: config copy plus per-list state.
  // ---------------------------------------------------------------------------
  logic [arc_pkg::POS_WIDTH-1:0]   extent_q = '0;
  logic                            unbounded_q = 1'b0;
  logic [arc_pkg::POS_WIDTH:0]     nxt_pos = '0;     // end of previous range + 1
  logic [arc_pkg::POS_WIDTH-1:0]   run_base = '0;
  logic [arc_pkg::TOTAL_WIDTH-1:0] run_span = '0;
  logic [arc_pkg::TOTAL_WIDTH:0]   sel_sum = '0;
  logic [arc_pkg::TOTAL_WIDTH-1:0] run_cnt = '0;
  logic [arc_pkg::TOTAL_WIDTH-1:0] item_cnt = '0;
  logic                            skip_rest = 1'b0; // error hit mid-list, drop to list end

  function automatic void clear_list();
    nxt_pos   = '0;
    run_base  = '0;
    run_span  = '0;
    sel_sum   = '0;
    run_cnt   = '0;
    item_cnt  = '0;
    skip_rest = 1'b0;
  endfunction

  function automatic void post_result(input logic [arc_pkg::POS_WIDTH-1:0] rs,
                                      input logic [arc_pkg::TOTAL_WIDTH-1:0] rl,
                                      input arc_pkg::err_code_t code,
                                      input logic [arc_pkg::TOTAL_WIDTH-1:0] st,
                                      input logic [arc_pkg::TOTAL_WIDTH-1:0] rt,
                                      input logic [arc_pkg::TOTAL_WIDTH-1:0] is,
                                      input logic fin);
    arc_pkg::result_t r;
    r.run_start      = rs;
    r.run_length     = rl;
    r.error_code     = code;
    r.selected_total = st;
    r.runs_total     = rt;
    r.items_seen     = is;
    r.final_res      = fin;
    expected_runs.push_back(r);
  endfunction

  // Predict the results of one accepted range request.
  function automatic void coalesce_range(input logic [arc_pkg::POS_WIDTH-1:0] st,
                                         input logic signed [arc_pkg::LEN_WIDTH-1:0] len,
                                         input logic last);
    logic [arc_pkg::POS_WIDTH+1:0]   end_pos;
    logic [arc_pkg::TOTAL_WIDTH+2:0] new_sum;
    arc_pkg::err_code_t              code;
    if (skip_rest) begin
      if (last) clear_list();
      return;
    end
    if (item_cnt != arc_pkg::TOT_MAX) item_cnt++;
    code    = arc_pkg::ERR_OK;
    end_pos = {2'b00, st} + (arc_pkg::POS_WIDTH+2)'(len[arc_pkg::LEN_WIDTH-2:0]) - 1'b1;
    new_sum = (arc_pkg::TOTAL_WIDTH+3)'(sel_sum)
            + (arc_pkg::TOTAL_WIDTH+3)'(len[arc_pkg::LEN_WIDTH-2:0]);
    // checks in priority order; a zero count skips all but the sign check
    if (len < 0) begin
      code = arc_pkg::ERR_NEG_COUNT;
    end else if (len != 0) begin
      if (st == '0) code = arc_pkg::ERR_START_LOW;
      else if ({1'b0, st} < nxt_pos) code = arc_pkg::ERR_NOT_ASCENDING;
      else if (!unbounded_q && end_pos > {2'b00, extent_q}) code = arc_pkg::ERR_BEYOND_EXTENT;
      else if (new_sum > (arc_pkg::TOTAL_WIDTH+3)'(arc_pkg::TOT_MAX))
        code = arc_pkg::ERR_TOO_LARGE;
    end
    if (code != arc_pkg::ERR_OK) begin
      // totals as before the failing range, item count including it
      post_result('0, '0, code, sel_sum[arc_pkg::TOTAL_WIDTH-1:0], run_cnt, item_cnt, 1'b1);
      if (last) clear_list();
      else skip_rest = 1'b1;
      return;
    end
    if (len != 0) begin
      if (run_cnt != 0 && {1'b0, st} == nxt_pos) begin
        run_span += len[arc_pkg::TOTAL_WIDTH-1:0];
      end else begin
        // a gap closes the open run
        if (run_cnt != 0)
          post_result(run_base, run_span, arc_pkg::ERR_OK, '0, '0, '0, 1'b0);
        run_base = st;
        run_span = len[arc_pkg::TOTAL_WIDTH-1:0];
        run_cnt++;
      end
      nxt_pos = {1'b0, st} + (arc_pkg::POS_WIDTH+1)'(len[arc_pkg::LEN_WIDTH-2:0]);
      sel_sum = new_sum[arc_pkg::TOTAL_WIDTH:0];
    end
    if (last) begin
      post_result(run_base, run_span, arc_pkg::ERR_OK, sel_sum[arc_pkg::TOTAL_WIDTH-1:0],
                  run_cnt, item_cnt, 1'b1);
      clear_list();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offers queued ranges, holds payload until accepted, and
  // feeds every accepted request to the predictor at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    range_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) coalesce_range(in_range_start, in_range_length, in_list_end);
      // free to change the payload only when nothing is held or it just went
      if (!in_valid || in_ready) begin
        if (pending_ranges.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = pending_ranges.pop_front();
          in_valid        <= 1'b1;
          in_range_start  <= nxt.start;
          in_range_length <= nxt.count;
          in_list_end     <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest prediction,
  // then throttles out_ready for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    arc_pkg::result_t got, want;
    logic             bad;
    if (rst_n && out_valid && out_ready) begin
      got.run_start      = out_run_start;
      got.run_length     = out_run_length;
      got.error_code     = arc_pkg::err_code_t'(out_error_code);
      got.selected_total = out_selected_total;
      got.runs_total     = out_runs_total;
      got.items_seen     = out_items_seen;
      got.final_res      = out_final_res;
      if (expected_runs.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("%0t unexpected result %p", $realtime, got);
      end else begin
        want = expected_runs.pop_front();
        bad = (got.run_start !== want.run_start) || (got.run_length !== want.run_length) ||
              (got.error_code !== want.error_code) ||
              (got.selected_total !== want.selected_total) ||
              (got.runs_total !== want.runs_total) ||
              (got.items_seen !== want.items_seen) || (got.final_res !== want.final_res);
        if (bad) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t mismatch exp: start=%h len=%h err=%0d sel=%h runs=%h items=%h fin=%b",
                     $realtime, want.run_start, want.run_length, want.error_code,
                     want.selected_total, want.runs_total, want.items_seen, want.final_res);
            $display("%0t          got: start=%h len=%h err=%0d sel=%h runs=%h items=%h fin=%b",
                     $realtime, got.run_start, got.run_length, got.error_code,
                     got.selected_total, got.runs_total, got.items_seen, got.final_res);
          end
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input arc_pkg::cfg_idx_t idx,
                           input logic [arc_pkg::CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == arc_pkg::CFG_EXTENT) extent_q = val[arc_pkg::POS_WIDTH-1:0];
    else unbounded_q = val[0];
  endtask

  function automatic void push_range(input logic [arc_pkg::POS_WIDTH-1:0] st,
                                     input logic signed [arc_pkg::LEN_WIDTH-1:0] len,
                                     input logic last);
    range_req_t r;
    r.start = st;
    r.count = len;
    r.last  = last;
    pending_ranges.push_back(r);
  endfunction

  // Waits until every range is sent and every prediction has been met, then waits out the
  // pipeline so dropped requests are done too (block is idle after this).
  task automatic drain();
    do @(negedge clk);
    while (pending_ranges.size() != 0 || in_valid || expected_runs.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Random position no larger than lim, spread over all magnitudes.
  function automatic logic [arc_pkg::POS_WIDTH-1:0] rand_pos(
      input logic [arc_pkg::POS_WIDTH-1:0] lim);
    logic [63:0] r;
    r = {$urandom, $urandom} >> $urandom_range(16, 63);
    if (r > 64'(lim)) r = r % (64'(lim) + 64'd1);
    return r[arc_pkg::POS_WIDTH-1:0];
  endfunction

  // Mostly well-formed ascending lists (touching or gapped ranges), with
  // zero counts, negative counts, zero starts, backward starts and noise mixed in.
  task automatic queue_lists(input int target, input logic [arc_pkg::POS_WIDTH-1:0] lim);
    int                                   made;
    int                                   n;
    int                                   kind;
    logic [arc_pkg::POS_WIDTH:0]          pos;
    logic [arc_pkg::POS_WIDTH-1:0]        st;
    logic signed [arc_pkg::LEN_WIDTH-1:0] ln;
    made = 0;
    while (made < target) begin
      n   = $urandom_range(1, 8);
      pos = (arc_pkg::POS_WIDTH+1)'(rand_pos(lim >> 1)) + 1'b1;
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
          st = ($urandom_range(0, 2) == 0) ? pos[arc_pkg::POS_WIDTH-1:0]
                                           : pos[arc_pkg::POS_WIDTH-1:0] + $urandom_range(1, 40);
          ln = ($urandom_range(0, 19) == 0)
               ? arc_pkg::LEN_WIDTH'($urandom_range(1, 32'h7FFF_FFFF))
               : arc_pkg::LEN_WIDTH'($urandom_range(1, 16));
        end else if (kind < 78) begin
          st = rand_pos(lim);
          ln = '0;
        end else if (kind < 84) begin
          st = rand_pos(lim);
          ln = {1'b1, 31'($urandom)};
        end else if (kind < 89) begin
          st = '0;
          ln = arc_pkg::LEN_WIDTH'($urandom_range(1, 16));
        end else if (kind < 95) begin
          st = pos[arc_pkg::POS_WIDTH-1:0] - $urandom_range(1, 8);
          ln = arc_pkg::LEN_WIDTH'($urandom_range(1, 16));
        end else begin
          st = arc_pkg::POS_WIDTH'({$urandom, $urandom});
          ln = $urandom;
        end
        push_range(st, ln, i == n - 1);
        if (kind < 72)
          pos = {1'b0, st} + (arc_pkg::POS_WIDTH+1)'(ln[arc_pkg::LEN_WIDTH-2:0]);
      end
      made += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bounded extent of 100
    write_reg(arc_pkg::CFG_EXTENT, 100);
    write_reg(arc_pkg::CFG_UNBOUNDED, 0);
    push_range(5, 3, 1'b0);          // opens a run
    push_range(8, 2, 1'b0);          // touches, merges
    push_range(20, 0, 1'b0);         // zero count skipped
    push_range(20, 1, 1'b0);         // gap: closes run 5..9
    push_range(21, 4, 1'b1);         // merge and close the list
    push_range(0, 1, 1'b1);          // start below one
    push_range(3, -1, 1'b1);         // negative count
    push_range(0, 0, 1'b1);          // list with nothing selected
    push_range(10, 5, 1'b0);
    push_range(12, 1, 1'b0);         // overlaps previous: error mid-list
    push_range(50, 1, 1'b0);         // dropped
    push_range(60, 1, 1'b1);         // dropped, clears the list
    push_range(95, 6, 1'b1);         // ends exactly at the extent
    push_range(95, 7, 1'b1);         // one past the extent
    push_range(10, 1, 1'b0);
    push_range(20, 1, 1'b1);         // list end opening a new run: two results
    drain();

    // directed: unbounded extent, total overflow and field extremes
    write_reg(arc_pkg::CFG_UNBOUNDED, 1);
    write_reg(arc_pkg::CFG_EXTENT, 0);
    push_range(1, 32'sh7FFF_FFFF, 1'b0);
    push_range(48'h0000_8000_0000, 1, 1'b1);        // sum passes the total limit
    push_range('1, 32'sh7FFF_FFFF, 1'b1);           // top start, largest count
    push_range(5, 32'sh8000_0000, 1'b1);            // most negative count
    push_range(48'h0000_0000_0100, 0, 1'b0);
    push_range(48'h7FFF_FFFF_FFFF, 4, 1'b1);
    drain();

    // random, sender idles 30%, receiver 60%, small bounded extent
    write_reg(arc_pkg::CFG_UNBOUNDED, 0);
    write_reg(arc_pkg::CFG_EXTENT, 1000);
    queue_lists(350, 48'd1000);
    drain();

    // random, sender 60%, receiver 30%, largest bounded extent
    send_idle = 60;
    recv_idle = 30;
    write_reg(arc_pkg::CFG_EXTENT, '1);
    queue_lists(350, '1);
    drain();

    // random at full rate: unbounded (extent value must be ignored), then extent zero
    send_idle = 0;
    recv_idle = 0;
    write_reg(arc_pkg::CFG_UNBOUNDED, 1);
    write_reg(arc_pkg::CFG_EXTENT, 48'd7);
    queue_lists(350, '1);
    drain();
    write_reg(arc_pkg::CFG_UNBOUNDED, 0);
    write_reg(arc_pkg::CFG_EXTENT, 0);
    queue_lists(120, 48'd1000);
    drain();

    if (n_bad == 0 && expected_runs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/arc_pkg.sv
rtl/arc_core.sv
rtl/arc_fifo.sv
rtl/ascending_range_coalescer.sv
sim/tb_top.sv
